[design/d96i_pkg.sv]
// shared types and constants for the decimal96_to_int32 block
package d96i_pkg;

   // mantissa is worked on as six 16-bit digits, most significant first
   localparam int unsigned HALF_W      = 16;
   localparam int unsigned NUM_HALVES  = 6;
   localparam int unsigned DIGIT_IDX_W = $clog2(NUM_HALVES);
   localparam int unsigned PARTIAL_W   = HALF_W + 4;

   // divide-by-ten reciprocal, exact for any dividend below 2^20
   localparam int unsigned DIV10_MULT  = 838861;
   localparam int unsigned DIV10_SHIFT = 23;

   localparam int unsigned MAX_SCALE_OK = 28;
   // 10^29 exceeds 2^96, so later divisions cannot change a zero quotient
   localparam int unsigned MAX_DIVS     = 29;
   localparam int unsigned STEP_W       = 5;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SCALE    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
   } result_type;

endpackage

[design/d96i_div10.sv]
// one-digit divide by ten: 20-bit partial dividend to 16-bit quotient and 4-bit remainder
module d96i_div10 (
   input  logic [d96i_pkg::PARTIAL_W-1:0] dividend,
   output logic [d96i_pkg::HALF_W-1:0]    quotient,
   output logic [3:0]                     remainder
);

   localparam int unsigned PW = d96i_pkg::PARTIAL_W;
   localparam int unsigned HW = d96i_pkg::HALF_W;
   localparam int unsigned SH = d96i_pkg::DIV10_SHIFT;

   logic [2*PW-1:0] product;
   logic [PW-1:0]   times_ten;

   assign product   = dividend * PW'(d96i_pkg::DIV10_MULT);
   assign quotient  = product[SH+HW-1:SH];
   assign times_ten = PW'({quotient, 3'b000}) + PW'({quotient, 1'b0});
   assign remainder = 4'(dividend - times_ten);

endmodule

[design/d96i_core.sv]
// sequencer that reuses the divide-by-ten unit one digit per cycle, then range-checks
module d96i_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_mantissa_low,
   input  logic [31:0]          req_mantissa_mid,
   input  logic [31:0]          req_mantissa_high,
   input  logic [7:0]           req_scale,
   input  logic                 req_negative,
   output logic                 done_valid,
   input  logic                 done_take,
   output d96i_pkg::result_type done_result
);

   localparam int unsigned HW = d96i_pkg::HALF_W;
   localparam int unsigned NH = d96i_pkg::NUM_HALVES;
   localparam int unsigned DW = d96i_pkg::DIGIT_IDX_W;
   localparam int unsigned SW = d96i_pkg::STEP_W;

   d96i_pkg::state_type state_ff, state_in;

   logic [HW-1:0] mant_ff [NH];
   logic [HW-1:0] mant_in [NH];
   logic [DW-1:0] digit_ff, digit_in;
   logic [3:0]    rem_ff, rem_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic          neg_ff, neg_in;
   logic          scale_big_ff, scale_big_in;

   logic                          accept;
   logic                          pass_start;
   logic                          mant_zero;
   logic                          finished;
   logic [d96i_pkg::PARTIAL_W-1:0] partial;
   logic [HW-1:0]                 quo;
   logic [3:0]                    rem_out;
   logic [95:0]                   mant_flat;
   logic [31:0]                   low_word;
   logic                          upper_nonzero;

   assign accept     = req_valid && !req_stall;
   assign pass_start = (digit_ff == DW'(NH - 1));
   assign mant_flat  = {mant_ff[5], mant_ff[4], mant_ff[3], mant_ff[2], mant_ff[1], mant_ff[0]};
   assign mant_zero  = (mant_flat == 96'd0);
   assign finished   = pass_start && ((steps_ff == '0) || mant_zero);
   assign partial    = {rem_ff, mant_ff[digit_ff]};

   d96i_div10 u_div10 (
      .dividend  (partial),
      .quotient  (quo),
      .remainder (rem_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         d96i_pkg::ST_IDLE: begin
            if (req_valid) state_in = d96i_pkg::ST_DIV;
         end
         d96i_pkg::ST_DIV: begin
            if (finished) state_in = d96i_pkg::ST_DONE;
         end
         d96i_pkg::ST_DONE: begin
            if (done_take) state_in = d96i_pkg::ST_IDLE;
         end
         default: state_in = d96i_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      done_valid = 1'b0;
      unique case (state_ff)
         d96i_pkg::ST_IDLE: req_stall  = 1'b0;
         d96i_pkg::ST_DIV:  req_stall  = 1'b1;
         d96i_pkg::ST_DONE: done_valid = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      mant_in      = mant_ff;
      digit_in     = digit_ff;
      rem_in       = rem_ff;
      steps_in     = steps_ff;
      neg_in       = neg_ff;
      scale_big_in = scale_big_ff;
      if (accept) begin
         mant_in[0]   = req_mantissa_low[15:0];
         mant_in[1]   = req_mantissa_low[31:16];
         mant_in[2]   = req_mantissa_mid[15:0];
         mant_in[3]   = req_mantissa_mid[31:16];
         mant_in[4]   = req_mantissa_high[15:0];
         mant_in[5]   = req_mantissa_high[31:16];
         digit_in     = DW'(NH - 1);
         rem_in       = 4'd0;
         steps_in     = (req_scale > 8'(d96i_pkg::MAX_DIVS)) ? SW'(d96i_pkg::MAX_DIVS)
                                                              : SW'(req_scale);
         neg_in       = req_negative;
         scale_big_in = (req_scale > 8'(d96i_pkg::MAX_SCALE_OK));
      end else if (state_ff == d96i_pkg::ST_DIV && !finished) begin
         mant_in[digit_ff] = quo;
         if (digit_ff == '0) begin
            // end of one full divide by ten
            digit_in = DW'(NH - 1);
            rem_in   = 4'd0;
            steps_in = steps_ff - SW'(1);
         end else begin
            digit_in = digit_ff - DW'(1);
            rem_in   = rem_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= d96i_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mant_ff      <= mant_in;
      digit_ff     <= digit_in;
      rem_ff       <= rem_in;
      steps_ff     <= steps_in;
      neg_ff       <= neg_in;
      scale_big_ff <= scale_big_in;
   end

   // range check and sign
   assign low_word      = mant_flat[31:0];
   assign upper_nonzero = (mant_flat[95:32] != 64'd0);

   always_comb begin
      done_result.value  = 32'd0;
      done_result.status = d96i_pkg::STATUS_OK;
      if (upper_nonzero) begin
         done_result.status = d96i_pkg::STATUS_OVERFLOW;
      end else if (low_word[31] && !(neg_ff && low_word == 32'h8000_0000)) begin
         done_result.status = d96i_pkg::STATUS_OVERFLOW;
      end else begin
         done_result.value = neg_ff ? (32'd0 - low_word) : low_word;
         if (scale_big_ff) done_result.status = d96i_pkg::STATUS_SCALE;
      end
   end

endmodule

[design/decimal96_to_int32_top.sv]
// top level: decimal to signed 32-bit conversion with registered result stage
//
// Converts a decimal (96-bit unsigned mantissa, 8-bit scale, sign) to a
// signed 32-bit integer, truncating toward zero.
// Request channel req_*: taken at a clock edge with req_valid high and
// req_stall low. Response channel rsp_*: taken with rsp_valid high and
// rsp_stall low; rsp_status is 0 ok, 1 scale above 28, 2 overflow (value 0).
// Each divide by ten walks the mantissa as six 16-bit digits through one
// shared divide-by-ten unit, one digit per cycle. Divisions stop at
// min(scale, 29) or as soon as the mantissa is zero at a pass boundary.
// With the response register free, a request runs its divisions in the core,
// passes through the done state and then moves into the response register.
// One request is in work at a time; the next request is taken once the
// result has moved into the response register, and a stalled response
// holds at most one result.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
// While rsp_stall is high with rsp_valid set, the response holds steady and a finished
// conversion waits in the core.
module decimal96_to_int32_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_mantissa_low,
   input  logic [31:0]       req_mantissa_mid,
   input  logic [31:0]       req_mantissa_high,
   input  logic [7:0]        req_scale,
   input  logic              req_negative,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]        rsp_status
);

   logic                 done_valid;
   logic                 done_take;
   d96i_pkg::result_type done_result;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   d96i_core u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mantissa_low  (req_mantissa_low),
      .req_mantissa_mid  (req_mantissa_mid),
      .req_mantissa_high (req_mantissa_high),
      .req_scale         (req_scale),
      .req_negative      (req_negative),
      .done_valid        (done_valid),
      .done_take         (done_take),
      .done_result       (done_result)
   );

   // load when the response register is empty or being drained
   assign done_take = done_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (done_take) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = done_result.value;
         rsp_status_in = done_result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = signed'(rsp_value_ff);
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a conversion was in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == d96i_pkg::STATUS_OK ||
                     rsp_status == d96i_pkg::STATUS_SCALE ||
                     rsp_status == d96i_pkg::STATUS_OVERFLOW))
      else $error("undefined response status");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == d96i_pkg::STATUS_OVERFLOW) |-> (rsp_value == 32'sd0))
      else $error("overflow response with nonzero value");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && done_valid) |=> rsp_valid)
      else $error("response dropped while stalled");
`endif

endmodule

[test/decimal96_to_int32_checker.sv]
// checker for decimal96_to_int32: predicts each response and compares it
module decimal96_to_int32_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [31:0]       req_mantissa_low,
   input  logic [31:0]       req_mantissa_mid,
   input  logic [31:0]       req_mantissa_high,
   input  logic [7:0]        req_scale,
   input  logic              req_negative,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic signed [31:0] rsp_value,
   input  logic [1:0]        rsp_status,
   output int                mismatch_count,
   output int                pending_count,
   output int                checked_count,
   output int                in_range_count,
   output int                scale_count,
   output int                overflow_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PRINTED = 100;

   d96i_pkg::result_type expected_results[$];
   int fails = 0;
   int checked = 0;
   int fitting = 0;
   int scale_errors = 0;
   int overflows = 0;

   // truncating conversion of one decimal to a signed 32-bit integer
   function automatic d96i_pkg::result_type convert_decimal(input logic [95:0] mantissa,
                                                            input logic [7:0] scale,
                                                            input logic negative);
      logic [95:0]          quotient;
      d96i_pkg::result_type res;
      quotient = mantissa;
      // once the quotient is zero further divisions change nothing
      for (int i = 0; i < scale && quotient != '0; i++)
         quotient = quotient / 96'd10;
      res.value  = '0;
      res.status = d96i_pkg::STATUS_OK;
      if (quotient[95:32] != '0) begin
         res.status = d96i_pkg::STATUS_OVERFLOW;
      end else if (quotient[31:0] == 32'h8000_0000 && negative) begin
         res.value = 32'h8000_0000;
      end else if (quotient[31]) begin
         res.status = d96i_pkg::STATUS_OVERFLOW;
      end else begin
         res.value = negative ? 32'd0 - quotient[31:0] : quotient[31:0];
      end
      if (res.status == d96i_pkg::STATUS_OK && scale > d96i_pkg::MAX_SCALE_OK)
         res.status = d96i_pkg::STATUS_SCALE;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fails < MAX_PRINTED)
         $display("%0t ns: %s", $time, msg);
      fails++;
   endtask

   always @(posedge clock) begin : watch
      d96i_pkg::result_type want;
      if (!reset) begin
         // a response never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response value %0d status %0d with no request waiting",
                                         rsp_value, rsp_status));
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_value, $signed(want.value)));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
         end
         if (req_valid && !req_stall) begin
            want = convert_decimal({req_mantissa_high, req_mantissa_mid, req_mantissa_low},
                                   req_scale, req_negative);
            expected_results.push_back(want);
            case (want.status)
               d96i_pkg::STATUS_OK:    fitting++;
               d96i_pkg::STATUS_SCALE: scale_errors++;
               default:                overflows++;
            endcase
         end
      end
      mismatch_count <= fails;
      pending_count  <= expected_results.size();
      checked_count  <= checked;
      in_range_count <= fitting;
      scale_count    <= scale_errors;
      overflow_count <= overflows;
   end

endmodule

[test/decimal96_to_int32_top_tb.sv]
// testbench top for decimal96_to_int32: stimulus, idle and stall mixes and verdict
module decimal96_to_int32_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 263;
   localparam int QUIET_LIMIT      = 5000;
   localparam int DRAIN_CYCLES     = 200;
   localparam int NUM_PHASES       = 4;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [31:0]       req_mantissa_low;
   logic [31:0]       req_mantissa_mid;
   logic [31:0]       req_mantissa_high;
   logic [7:0]        req_scale;
   logic              req_negative;
   logic              rsp_valid;
   logic              rsp_stall;
   logic signed [31:0] rsp_value;
   logic [1:0]        rsp_status;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int in_range_count;
   int scale_count;
   int overflow_count;

   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int directed_count = 0;
   int random_count = 0;
   int idle_by_phase[NUM_PHASES]  = '{0, 88, 0, 9};
   int stall_by_phase[NUM_PHASES] = '{0, 0, 88, 9};

   always #1 clock = ~clock;

   decimal96_to_int32_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mantissa_low  (req_mantissa_low),
      .req_mantissa_mid  (req_mantissa_mid),
      .req_mantissa_high (req_mantissa_high),
      .req_scale         (req_scale),
      .req_negative      (req_negative),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status)
   );

   decimal96_to_int32_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mantissa_low  (req_mantissa_low),
      .req_mantissa_mid  (req_mantissa_mid),
      .req_mantissa_high (req_mantissa_high),
      .req_scale         (req_scale),
      .req_negative      (req_negative),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .in_range_count    (in_range_count),
      .scale_count       (scale_count),
      .overflow_count    (overflow_count)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ends the run when neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [127:0] power_of_ten(input int unsigned exponent);
      logic [127:0] p;
      p = 128'd1;
      for (int i = 0; i < exponent; i++)
         p = p * 128'd10;
      return p;
   endfunction

   task automatic send_request(input logic [95:0] mantissa, input logic [7:0] scl,
                               input logic neg);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mantissa_low  <= mantissa[31:0];
      req_mantissa_mid  <= mantissa[63:32];
      req_mantissa_high <= mantissa[95:64];
      req_scale         <= scl;
      req_negative      <= neg;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_directed(input logic [95:0] mantissa, input logic [7:0] scl,
                                input logic neg);
      send_request(mantissa, scl, neg);
      directed_count++;
   endtask

   // mostly built as quotient * 10^scale + remainder so results land near the limits
   task automatic send_random_request();
      logic [127:0] pow;
      logic [127:0] rem;
      logic [127:0] q;
      logic [127:0] m;
      logic [7:0]   scl;
      scl = 8'($urandom_range(28));
      if ($urandom_range(99) < 20) begin
         m   = {32'd0, $urandom, $urandom, $urandom};
         scl = 8'($urandom_range(255));
      end else begin
         case ($urandom_range(6))
            0:       q = '0;
            1:       q = 128'h8000_0000 + 128'($urandom_range(2)) - 128'd1;
            2:       q = 128'($urandom_range(32'h7fff_ffff));
            3:       q = 128'($urandom_range(999));
            4:       q = 128'($urandom);
            5:       q = 128'({$urandom, $urandom}) >> $urandom_range(63);
            default: q = 128'({$urandom, $urandom, $urandom}) >> $urandom_range(95);
         endcase
         pow = power_of_ten(32'(scl));
         case ($urandom_range(3))
            0:       rem = '0;
            1:       rem = pow - 128'd1;
            default: rem = {$urandom, $urandom, $urandom, $urandom} % pow;
         endcase
         m = q * pow + rem;
         if (m[127:96] != '0) begin
            m   = q;
            scl = '0;
         end
      end
      send_request(m[95:0], scl, 1'($urandom_range(1)));
      random_count++;
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_mantissa_low  <= '0;
      req_mantissa_mid  <= '0;
      req_mantissa_high <= '0;
      req_scale         <= '0;
      req_negative      <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero and negative zero
      send_directed(96'd0, 8'd0, 1'b0);
      send_directed(96'd0, 8'd0, 1'b1);
      // edges of the signed range
      send_directed(96'h7fff_ffff, 8'd0, 1'b0);
      send_directed(96'h7fff_ffff, 8'd0, 1'b1);
      send_directed(96'h8000_0000, 8'd0, 1'b1);
      send_directed(96'h8000_0000, 8'd0, 1'b0);
      send_directed(96'hffff_ffff, 8'd0, 1'b0);
      send_directed(96'h1_0000_0000, 8'd0, 1'b1);
      send_directed({96{1'b1}}, 8'd0, 1'b1);
      // largest mantissa across the scale limit
      send_directed({96{1'b1}}, 8'd28, 1'b0);
      send_directed({96{1'b1}}, 8'd29, 1'b0);
      send_directed({96{1'b1}}, 8'd255, 1'b1);
      send_directed(96'd0, 8'd29, 1'b1);
      // truncation landing right on the range edges
      send_directed(96'd21474836489, 8'd1, 1'b1);
      send_directed(96'd21474836480, 8'd1, 1'b0);
      send_directed(96'd21474836479, 8'd1, 1'b0);
      send_directed(96'd21474836479, 8'd1, 1'b1);
      send_directed(96'(power_of_ten(28) * 5 + power_of_ten(28) - 1), 8'd28, 1'b1);
      send_directed(96'd12345, 8'd2, 1'b1);
      send_directed(96'hffff_ffff, 8'd1, 1'b0);
      send_directed({$urandom, $urandom, $urandom}, 8'h80, 1'b0);
      send_directed(96'd999, 8'd3, 1'b1);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_random_request();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests (%0d directed, %0d random) under four idle and stall mixes",
               directed_count + random_count, directed_count, random_count);
      $display("checked %0d responses: %0d in range, %0d scale above 28, %0d overflow",
               checked_count, in_range_count, scale_count, overflow_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
design/d96i_pkg.sv
design/d96i_div10.sv
design/d96i_core.sv
design/decimal96_to_int32_top.sv
test/decimal96_to_int32_checker.sv
test/decimal96_to_int32_top_tb.sv
